### rtl/crc32e_pkg.sv
// crc32e_pkg: shared types, constants and the byte fold function for the
// CRC-32 eight byte stream core. No dependencies.

package crc32e_pkg;

    localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
    localparam logic [31:0] CRC_ONES    = 32'hFFFF_FFFF;
    localparam int          FIELD_BYTES = 8;

    typedef struct packed {
        logic [63:0] data;
        logic [3:0]  count;
        logic        first;
        logic        last;
    } t_item;

    // One reflected CRC-32 byte step, eight bit shifts.
    function automatic logic [31:0] crc_fold_byte(input logic [31:0] rem,
                                                  input logic [7:0]  data_byte);
        logic [31:0] r;
        r = rem ^ {24'd0, data_byte};
        for (int b = 0; b < 8; b++) begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

endpackage

### rtl/crc32e_front.sv
// crc32e_front: input side, saturates the byte count and builds the queue item.
// Depends on crc32e_pkg.

module crc32e_front
    import crc32e_pkg::*;
#(
    parameter int LIMIT = 8
) (
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [63:0] i_data_bytes,
    input  logic [3:0]  i_byte_count,
    input  logic        i_first_item,
    input  logic        i_last_item,
    input  logic        i_q_full,
    output logic        o_q_push,
    output t_item       o_q_item
);

    localparam logic [3:0] LIMIT_CNT = 4'(LIMIT);

    assign o_ready  = !i_q_full;
    assign o_q_push = i_valid && !i_q_full;

    always_comb begin
        o_q_item.data  = i_data_bytes;
        o_q_item.count = (i_byte_count > LIMIT_CNT) ? LIMIT_CNT : i_byte_count;
        o_q_item.first = i_first_item;
        o_q_item.last  = i_last_item;
    end

endmodule

### rtl/crc32e_fifo.sv
// crc32e_fifo: two entry item queue between the front and the CRC engine.
// Depends on crc32e_pkg.

module crc32e_fifo
    import crc32e_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_item o_item
);

    t_item      r_mem [0:1];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] n_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_item  = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= n_count;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'd2)
        else $error("queue count out of range");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + 2'd1))
        else $error("queue count did not grow on push");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd1) |-> (r_wr_ptr != r_rd_ptr))
        else $error("queue pointers disagree with count");

endmodule

### rtl/crc32e_back.sv
// crc32e_back: CRC engine, folds up to eight bytes per item into the running
// remainder and holds the result in an output register. Depends on crc32e_pkg.

module crc32e_back
    import crc32e_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_item       i_q_item,
    output logic        o_q_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_crc_value
);

    logic [31:0] r_rem;
    logic [31:0] n_rem;
    logic [31:0] r_crc;
    logic        r_out_valid;
    logic        out_free;

    assign out_free    = !r_out_valid || i_ready;
    assign o_q_pop     = i_q_valid && (!i_q_item.last || out_free);
    assign o_valid     = r_out_valid;
    assign o_crc_value = r_crc;

    always_comb begin
        n_rem = i_q_item.first ? CRC_ONES : r_rem;
        for (int i = 0; i < FIELD_BYTES; i++) begin
            if (4'(i) < i_q_item.count) begin
                n_rem = crc_fold_byte(n_rem, i_q_item.data[8*i +: 8]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem       <= CRC_ONES;
            r_out_valid <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_rem <= n_rem;
            end
            if (o_q_pop && i_q_item.last) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop && i_q_item.last) begin
            r_crc <= ~n_rem;
        end
    end

    a_last_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_q_pop && i_q_item.last) |=> r_out_valid)
        else $error("last item gave no result");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |-> !(o_q_pop && i_q_item.last))
        else $error("pending result overwritten");

    a_count_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_valid |-> (i_q_item.count <= 4'(FIELD_BYTES)))
        else $error("queued byte count not saturated");

endmodule

### rtl/crc32_eight_byte_stream_core.sv
// crc32_eight_byte_stream_core: top level of the streaming CRC-32 core.
// Depends on crc32e_pkg, crc32e_front, crc32e_fifo, crc32e_back.
//
// Reflected CRC-32 (poly 0xEDB88320, init all ones, final inversion) over a
// byte message delivered as items of up to eight little-endian bytes. The core
// takes one item per clock while its queue is not full: the byte fold is a
// combinational XOR network that closes the remainder loop every cycle. An
// accepted item enters a two entry queue and is folded when it is popped from
// the head; a last item's CRC goes from the queue into the output register,
// raises o_valid and waits there. Later items without the last flag keep
// flowing; the next last item waits at the head of the queue until the pending
// CRC is taken. Counts above min(BYTES_PER_ITEM, 8) are saturated.

module crc32_eight_byte_stream_core
    import crc32e_pkg::*;
#(
    parameter int BYTES_PER_ITEM = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [63:0] i_data_bytes,
    input  logic [3:0]  i_byte_count,
    input  logic        i_first_item,
    input  logic        i_last_item,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_crc_value
);

    localparam int LIMIT = (BYTES_PER_ITEM < FIELD_BYTES) ? BYTES_PER_ITEM : FIELD_BYTES;

    logic  q_full;
    logic  q_push;
    t_item q_in;
    logic  q_pop;
    logic  q_valid;
    t_item q_out;

    crc32e_front #(
        .LIMIT (LIMIT)
    ) u_front (
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_data_bytes (i_data_bytes),
        .i_byte_count (i_byte_count),
        .i_first_item (i_first_item),
        .i_last_item  (i_last_item),
        .i_q_full     (q_full),
        .o_q_push     (q_push),
        .o_q_item     (q_in)
    );

    crc32e_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_out)
    );

    crc32e_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_item    (q_out),
        .o_q_pop     (q_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_crc_value (o_crc_value)
    );

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// tb_top: self-checking testbench for crc32_eight_byte_stream_core.
// Holds a small CRC tracker class and the stimulus, response and watchdog processes.
// Depends on crc32e_pkg and the core's RTL.

class crc_checker;
    logic [31:0] remainder;
    logic [31:0] crc_due[$];
    int          fold_limit;
    int          mismatches;
    int          results_seen;

    function new(int bytes_per_item);
        fold_limit   = (bytes_per_item < crc32e_pkg::FIELD_BYTES) ?
                       bytes_per_item : crc32e_pkg::FIELD_BYTES;
        remainder    = crc32e_pkg::CRC_ONES;
        mismatches   = 0;
        results_seen = 0;
    endfunction

    // Reflected CRC step, one data bit injected at bit 0 per shift.
    function logic [31:0] fold_byte(logic [31:0] rem, logic [7:0] data_byte);
        logic [31:0] r;
        logic        carry;
        r = rem;
        for (int k = 0; k < 8; k++) begin
            carry = r[0] ^ data_byte[k];
            r = {1'b0, r[31:1]};
            if (carry) begin
                r = r ^ crc32e_pkg::CRC_POLY;
            end
        end
        return r;
    endfunction

    function void note_item(crc32e_pkg::t_item it);
        int n;
        n = (it.count > fold_limit) ? fold_limit : it.count;
        if (it.first) begin
            remainder = crc32e_pkg::CRC_ONES;
        end
        for (int i = 0; i < n; i++) begin
            remainder = fold_byte(remainder, it.data[8*i +: 8]);
        end
        if (it.last) begin
            crc_due.push_back(remainder ^ crc32e_pkg::CRC_ONES);
        end
    endfunction

    function void check_result(logic [31:0] got);
        logic [31:0] want;
        results_seen++;
        if (crc_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("tb_top: crc %08h arrived with none pending", got);
            end
        end else begin
            want = crc_due.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("tb_top: crc mismatch, expected %08h, got %08h", want, got);
                end
            end
        end
    endfunction

    function int pending();
        return crc_due.size();
    endfunction
endclass

module tb_top;
    import crc32e_pkg::*;

    localparam int BYTES_PER_ITEM = 8;
    localparam int ITEM_TARGET    = 1300;
    localparam int STALL_LIMIT    = 5000;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 20;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [63:0] i_data_bytes;
    logic [3:0]  i_byte_count;
    logic        i_first_item;
    logic        i_last_item;
    logic        o_valid;
    logic        i_ready;
    logic [31:0] o_crc_value;

    crc_checker  msg_crc;
    t_item       taken;
    bit          offering;
    bit          hold_req;
    int          burst_left;
    int          items_sent;
    int          saturated_items;
    int          empty_items;
    int          holds_done;
    int          drains_done;
    int          idle_run;

    crc32_eight_byte_stream_core #(
        .BYTES_PER_ITEM(BYTES_PER_ITEM)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data_bytes(i_data_bytes),
        .i_byte_count(i_byte_count),
        .i_first_item(i_first_item),
        .i_last_item (i_last_item),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_crc_value (o_crc_value)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic send_item(input logic [63:0] data, input logic [3:0] count,
                             input logic first, input logic last);
        i_valid      <= 1'b1;
        i_data_bytes <= data;
        i_byte_count <= count;
        i_first_item <= first;
        i_last_item  <= last;
        offering = 1'b1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        items_sent++;
        if (count > BYTES_PER_ITEM) saturated_items++;
        if (count == 0) empty_items++;
    endtask

    task automatic pace();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
            gap = $urandom_range(1, 8);
            i_valid <= 1'b0;
            offering = 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        if (offering) begin
            i_valid <= 1'b0;
            offering = 1'b0;
        end
        @(posedge i_clk);
        while (msg_crc.pending() != 0) @(posedge i_clk);
    endtask

    function automatic logic [3:0] pick_count();
        int r;
        r = $urandom_range(0, 19);
        if (r < 9) return 4'd8;
        if (r < 15) return 4'($urandom_range(1, 7));
        if (r < 17) return 4'd0;
        return 4'($urandom_range(9, 15));
    endfunction

    task automatic send_message(input int len, input bit noisy);
        logic [63:0] data;
        logic        first;
        logic        last;
        for (int i = 0; i < len; i++) begin
            data  = {$urandom(), $urandom()};
            first = noisy ? 1'($urandom_range(0, 1)) : (i == 0);
            last  = noisy ? 1'($urandom_range(0, 1)) : (i == len - 1);
            send_item(data, pick_count(), first, last);
            pace();
        end
    endtask

    task automatic directed_items();
        // "123456789" split 4+5, upper bytes garbage, no first flag after reset
        send_item(64'hdead_beef_3433_3231, 4'd4, 1'b0, 1'b0);
        pace();
        send_item(64'h5a5a_5a39_3837_3635, 4'd5, 1'b0, 1'b1);
        pace();
        // continues past a last item
        send_item(64'h0123_4567_89ab_cdef, 4'd3, 1'b0, 1'b1);
        send_item('1, 4'd0, 1'b1, 1'b1);
        send_item('1, 4'd8, 1'b1, 1'b0);
        send_item('0, 4'd8, 1'b0, 1'b1);
        send_item({$urandom(), $urandom()}, 4'd2, 1'b1, 1'b0);
        send_item({$urandom(), $urandom()}, 4'd0, 1'b0, 1'b0);
        send_item({$urandom(), $urandom()}, 4'd0, 1'b0, 1'b1);
        pace();
        for (int c = 9; c <= 15; c++) begin
            send_item((c == 15) ? '1 : {$urandom(), $urandom()}, 4'(c), 1'b1, 1'b1);
        end
        send_item('0, 4'd0, 1'b1, 1'b0);
        send_item(64'hff, 4'd1, 1'b0, 1'b1);
        for (int c = 1; c <= 7; c++) begin
            send_item({$urandom(), $urandom()}, 4'(c), 1'b1, 1'b1);
            pace();
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready) begin
            taken.data  = i_data_bytes;
            taken.count = i_byte_count;
            taken.first = i_first_item;
            taken.last  = i_last_item;
            msg_crc.note_item(taken);
        end
        if (i_rst_n && o_valid && i_ready) begin
            msg_crc.check_result(o_crc_value);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_run = 0;
        end else begin
            idle_run++;
            if (idle_run >= STALL_LIMIT) begin
                $display("tb_top: no handshake for %0d cycles", STALL_LIMIT);
                $display("tb_top: done, errors");
                $finish;
            end
        end
    end

    initial begin
        int rx_cycle;
        int hold_left;
        rx_cycle  = 0;
        hold_left = 0;
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            rx_cycle++;
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
                holds_done++;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                case ((rx_cycle / 97) % 5)
                    1: i_ready <= 1'($urandom_range(0, 1));
                    2: i_ready <= (rx_cycle % 4 == 0);
                    4: i_ready <= ($urandom_range(0, 3) != 0);
                    default: i_ready <= 1'b1;
                endcase
            end
        end
    end

    initial begin
        bit hold_fired;
        bit drain_fired;
        msg_crc = new(BYTES_PER_ITEM);
        hold_fired  = 1'b0;
        drain_fired = 1'b0;
        idle_run    = 0;
        burst_left  = 0;
        offering    = 1'b0;
        hold_req    = 1'b0;
        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_data_bytes <= '0;
        i_byte_count <= '0;
        i_first_item <= 1'b0;
        i_last_item  <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed_items();

        while (items_sent < ITEM_TARGET) begin
            if (!hold_fired && items_sent >= 400) begin
                hold_fired = 1'b1;
                hold_req   = 1'b1;
                burst_left = 120;
            end
            if (!drain_fired && items_sent >= 850) begin
                drain_fired = 1'b1;
                drain();
                drains_done++;
            end
            if ($urandom_range(0, 6) == 0) begin
                send_message($urandom_range(1, 3), 1'b1);
            end else begin
                send_message(($urandom_range(0, 9) == 0) ? $urandom_range(7, 20)
                                                         : $urandom_range(1, 5), 1'b0);
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("tb_top: %0d items (%0d over the byte limit, %0d with no bytes), %0d CRCs",
                 items_sent, saturated_items, empty_items, msg_crc.results_seen);
        $display("tb_top: %0d long receiver hold-off(s), %0d sender pause(s) to empty",
                 holds_done, drains_done);
        if (msg_crc.mismatches == 0 && msg_crc.pending() == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: %0d mismatches, %0d CRCs never seen",
                     msg_crc.mismatches, msg_crc.pending());
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
